### rtl/sensor_frame_deobfuscate_decoder_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the sensor frame decoder
// Short wrappers for concurrent checks that share one clock and reset.
// ----------------------------------------------------------------------------
`ifndef SENSOR_FRAME_DEOBFUSCATE_DECODER_ASSERT_SVH
`define SENSOR_FRAME_DEOBFUSCATE_DECODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFD_ASSERT_SAME(label, clk_sig, rstn_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SFD_ASSERT_NEXT(label, clk_sig, rstn_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rstn_sig) \
        (ante) |=> (cons)) else $error(msg);

`endif

### rtl/sfd_pkg.sv
// ----------------------------------------------------------------------------
// sfd_pkg
// Constants, result codes and CRC helpers for the sensor frame decoder.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam int KEY_WORDS     = 16;
    localparam int CAPTURE_BYTES = 14;
    localparam int CAP_IDX_W     = $clog2(CAPTURE_BYTES);

    localparam int STATUS_W = 3;
    localparam int TYPE_W   = 8;
    localparam int TDATA_W  = 128;
    localparam int TUSER_W  = STATUS_W + TYPE_W;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_CRC16_BAD = 3'd1;
    localparam logic [STATUS_W-1:0] ST_CRC8_BAD  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_LONG  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_TOO_SHORT = 3'd4;
    localparam logic [STATUS_W-1:0] ST_UNKNOWN   = 3'd5;

    // Frame type codes (payload byte 4).
    localparam logic [TYPE_W-1:0] TYPE_RAW_POWER = 8'd1;
    localparam logic [TYPE_W-1:0] TYPE_WEATHER   = 8'd2;
    localparam logic [TYPE_W-1:0] TYPE_BATT_LVL  = 8'd3;
    localparam logic [TYPE_W-1:0] TYPE_BATT_LOW  = 8'd4;

    localparam logic [7:0]  MAX_LENGTH_RST = 8'd60;
    localparam logic [7:0]  MIN_LENGTH     = 8'd5;
    localparam logic [7:0]  TYPE_POS       = 8'd4;
    localparam logic [16:0] TEMP_OFFSET    = 17'd2732;
    localparam logic [15:0] CRC16_POLY     = 16'h8005;
    localparam logic [15:0] CRC16_INIT     = 16'hFFFF;
    localparam logic [7:0]  CRC8_POLY      = 8'h07;

    localparam logic [7:0] KEY_TABLE [KEY_WORDS] = '{
        8'h19, 8'hF8, 8'h28, 8'h30, 8'h6D, 8'h0C, 8'h94, 8'h54,
        8'h22, 8'hF2, 8'h37, 8'hC9, 8'h66, 8'hA3, 8'h97, 8'h57
    };

    // One byte of CRC-16, MSB first.
    function automatic logic [15:0] crc16_feed(input logic [15:0] crc,
                                               input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
        begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC16_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    // One byte of CRC-8, MSB first.
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc,
                                             input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int k = 0; k < 8; k++)
        begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC8_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

### rtl/sensor_frame_deobfuscate_decoder.sv
// ----------------------------------------------------------------------------
// sensor_frame_deobfuscate_decoder
// Checks CRC-16 on framed sensor bytes, removes the XOR obfuscation and
// decodes one result per frame.
// ----------------------------------------------------------------------------
//  Channel  Dir  Payload
//  s_*      in   tdata[7:0] frame_byte, tuser[0] frame_start
//  m_*      out  tuser status/frame_type, tdata decoded fields (128 bits)
//  cfg_*    in   max_length, written when cfg_we is high
//
//  One beat per cycle sustained while results are taken; a beat is registered
//  in the input stage on entry and decoded from there into the result register.
//  The decode step is the byte-wide CRC-16/CRC-8 update and result muxing.
//  Reset clears the frame state; max_length returns to 60.
//  A stalled result holds the input stage, which then stalls the input.
// ----------------------------------------------------------------------------
`include "sensor_frame_deobfuscate_decoder_assert.svh"

module sensor_frame_deobfuscate_decoder
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // [7:0] frame_byte
    input  logic [0:0]                 s_tuser,   // [0] frame_start
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // [31:0] device_id, [48:32] temperature_tenths, [56:49] humidity,
    // [64:57] battery_percent, [88:65] power_index, [104:89] peak_power,
    // [125:105] timestamp_seconds, [127:126] zero
    output logic [sfd_pkg::TDATA_W-1:0] m_tdata,
    // [2:0] status, [10:3] frame_type
    output logic [sfd_pkg::TUSER_W-1:0] m_tuser,
    input  logic                       cfg_we,
    input  logic [7:0]                 cfg_wdata
);

    import sfd_pkg::*;

    typedef enum logic [1:0] {PH_IDLE, PH_DATA, PH_CRC_HI, PH_CRC_LO} phase_t;

    // Registers.
    logic [7:0]  max_length_reg;
    logic        stg_valid_reg, stg_valid_next;
    logic [7:0]  stg_byte_reg;
    logic        stg_start_reg;
    phase_t      phase_reg, phase_next;
    logic [7:0]  pos_reg, pos_next;
    logic [7:0]  len_reg, len_next;
    logic [15:0] crc16_reg, crc16_next;
    logic [7:0]  crc8_reg, crc8_next;
    logic [7:0]  prev_reg, prev_next;
    logic [7:0]  rx_hi_reg, rx_hi_next;
    logic [7:0]  cap_reg [CAPTURE_BYTES];
    logic [7:0]  cap_next [CAPTURE_BYTES];
    logic [7:0]  last_reg, last_next;
    logic                out_valid_reg, out_valid_next;
    logic [TDATA_W-1:0]  out_data_reg;
    logic [TUSER_W-1:0]  out_user_reg;

    logic        advance;
    logic        emit;
    logic [TDATA_W-1:0] res_data;
    logic [TUSER_W-1:0] res_user;

    // Frame-end decode.
    logic [STATUS_W-1:0] fin_status;
    logic [TYPE_W-1:0]   fin_type;
    logic [31:0]         fin_id;
    logic [16:0]         fin_temp;
    logic [7:0]          fin_hum;
    logic [7:0]          fin_batt;
    logic [23:0]         fin_pidx;
    logic [15:0]         fin_pmax;
    logic [20:0]         fin_ts;
    logic [23:0]         ts_raw;

    // Data byte helpers.
    logic [7:0]  pb;
    logic [7:0]  sub;
    logic [8:0]  pos_inc;

    // The staged beat moves on when the result slot is free or drains now.
    assign advance  = stg_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !stg_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    assign pos_inc = {1'b0, pos_reg} + 9'd1;
    assign sub     = len_reg - TYPE_POS;
    assign pb      = stg_byte_reg ^ KEY_TABLE[pos_reg[3:0]]
                   ^ ((pos_reg != 8'd0) ? prev_reg : 8'd0);
    assign ts_raw  = {cap_reg[9], cap_reg[10], cap_reg[11]};

    // Result of a frame once its low CRC byte arrives.
    always_comb
    begin
        fin_status = ST_OK;
        fin_type   = '0;
        fin_id     = '0;
        fin_temp   = '0;
        fin_hum    = '0;
        fin_batt   = '0;
        fin_pidx   = '0;
        fin_pmax   = '0;
        fin_ts     = '0;
        if ({rx_hi_reg, stg_byte_reg} != crc16_reg)
        begin
            fin_status = ST_CRC16_BAD;
        end
        else
        begin
            fin_type = cap_reg[4];
            fin_id   = {cap_reg[3], cap_reg[2], cap_reg[1], cap_reg[0]};
            unique case (cap_reg[4])
                TYPE_RAW_POWER:
                begin
                    if (crc8_reg != last_reg)
                    begin
                        fin_status = ST_CRC8_BAD;
                    end
                    else
                    begin
                        fin_pidx = {cap_reg[6], cap_reg[7], cap_reg[8]};
                        fin_ts   = ts_raw[23:3];
                        fin_pmax = {cap_reg[12], cap_reg[13]};
                    end
                end
                TYPE_WEATHER:
                begin
                    fin_temp = {1'b0, cap_reg[6], cap_reg[5]} - TEMP_OFFSET;
                    fin_hum  = cap_reg[7];
                end
                TYPE_BATT_LVL:
                begin
                    fin_batt = cap_reg[5];
                end
                TYPE_BATT_LOW:
                begin
                    fin_status = ST_OK;
                end
                default:
                begin
                    fin_status = ST_UNKNOWN;
                end
            endcase
        end
    end

    // Per-beat state update and result selection.
    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        len_next   = len_reg;
        crc16_next = crc16_reg;
        crc8_next  = crc8_reg;
        prev_next  = prev_reg;
        rx_hi_next = rx_hi_reg;
        last_next  = last_reg;
        cap_next   = cap_reg;
        emit       = 1'b0;
        res_data   = '0;
        res_user   = '0;
        if (advance)
        begin
            if (stg_start_reg)
            begin
                for (int j = 0; j < CAPTURE_BYTES; j++)
                begin
                    cap_next[j] = 8'd0;
                end
                pos_next   = 8'd0;
                len_next   = stg_byte_reg;
                crc16_next = crc16_feed(CRC16_INIT, stg_byte_reg);
                crc8_next  = 8'd0;
                last_next  = 8'd0;
                prev_next  = stg_byte_reg;
                phase_next = PH_IDLE;
                if (stg_byte_reg > max_length_reg)
                begin
                    emit     = 1'b1;
                    res_user = {{TYPE_W{1'b0}}, ST_TOO_LONG};
                end
                else if (stg_byte_reg < MIN_LENGTH)
                begin
                    emit     = 1'b1;
                    res_user = {{TYPE_W{1'b0}}, ST_TOO_SHORT};
                end
                else
                begin
                    phase_next = PH_DATA;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_DATA:
                    begin
                        crc16_next = crc16_feed(crc16_reg, stg_byte_reg);
                        if (pos_reg < CAPTURE_BYTES[7:0])
                        begin
                            cap_next[pos_reg[CAP_IDX_W-1:0]] = pb;
                        end
                        if (pos_reg == TYPE_POS)
                        begin
                            // The type byte enters the CRC-8 as len-4.
                            crc8_next = (len_reg > MIN_LENGTH) ? crc8_feed(8'd0, sub)
                                                               : 8'd0;
                            if (pos_inc == {1'b0, len_reg})
                            begin
                                last_next = sub;
                            end
                        end
                        else if (pos_reg > TYPE_POS)
                        begin
                            if (pos_inc < {1'b0, len_reg})
                            begin
                                crc8_next = crc8_feed(crc8_reg, pb);
                            end
                            else
                            begin
                                last_next = pb;
                            end
                        end
                        prev_next = stg_byte_reg;
                        pos_next  = pos_inc[7:0];
                        if (pos_inc >= {1'b0, len_reg})
                        begin
                            phase_next = PH_CRC_HI;
                        end
                    end
                    PH_CRC_HI:
                    begin
                        rx_hi_next = stg_byte_reg;
                        phase_next = PH_CRC_LO;
                    end
                    PH_CRC_LO:
                    begin
                        phase_next = PH_IDLE;
                        emit       = 1'b1;
                        res_user   = {fin_type, fin_status};
                        res_data   = {2'b00, fin_ts, fin_pmax, fin_pidx, fin_batt,
                                      fin_hum, fin_temp, fin_id};
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // Input stage and result valid.
    always_comb
    begin
        stg_valid_next = stg_valid_reg;
        if (s_tvalid && s_tready)
        begin
            stg_valid_next = 1'b1;
        end
        else if (advance)
        begin
            stg_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_length_reg <= MAX_LENGTH_RST;
            stg_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
            phase_reg      <= PH_IDLE;
            pos_reg        <= '0;
            len_reg        <= '0;
            crc16_reg      <= CRC16_INIT;
            crc8_reg       <= '0;
            prev_reg       <= '0;
            rx_hi_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                max_length_reg <= cfg_wdata;
            end
            stg_valid_reg <= stg_valid_next;
            out_valid_reg <= out_valid_next;
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            len_reg       <= len_next;
            crc16_reg     <= crc16_next;
            crc8_reg      <= crc8_next;
            prev_reg      <= prev_next;
            rx_hi_reg     <= rx_hi_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            stg_byte_reg  <= s_tdata;
            stg_start_reg <= s_tuser[0];
        end
        if (emit)
        begin
            out_data_reg <= res_data;
            out_user_reg <= res_user;
        end
        cap_reg  <= cap_next;
        last_reg <= last_next;
    end

    // Checks on the decoder's own logic.
    `SFD_ASSERT_SAME(a_stall_blocks_input, clk, rst_n,
        stg_valid_reg && out_valid_reg && !m_tready, !s_tready,
        "input taken while the staged beat is blocked")
    `SFD_ASSERT_SAME(a_emit_source, clk, rst_n,
        emit, stg_start_reg || (phase_reg == PH_CRC_LO),
        "result produced outside a frame start or frame end")
    `SFD_ASSERT_SAME(a_len_ok_in_frame, clk, rst_n,
        phase_reg != PH_IDLE, len_reg >= MIN_LENGTH,
        "frame in progress with a length below the minimum")
    `SFD_ASSERT_SAME(a_len_error_clean, clk, rst_n,
        m_tvalid && (m_tuser[STATUS_W-1:0] == ST_TOO_LONG
                     || m_tuser[STATUS_W-1:0] == ST_TOO_SHORT
                     || m_tuser[STATUS_W-1:0] == ST_CRC16_BAD),
        (m_tdata == '0) && (m_tuser[TUSER_W-1:STATUS_W] == '0),
        "error result carries nonzero fields")
    `SFD_ASSERT_NEXT(a_emit_shows, clk, rst_n,
        emit, m_tvalid,
        "emitted result not presented")

endmodule

### tb/sensor_frame_deobfuscate_decoder_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sensor frame decoder testbench
// Sends framed, obfuscated sensor bytes to the decoder. A behavioral copy of
// the frame checker predicts the result of every finished or rejected frame,
// and each result beat is compared field by field. Directed frames cover every
// frame type, every error status and the length limits. Random traffic then
// runs under three flow-control patterns.
// ----------------------------------------------------------------------------
module sensor_frame_deobfuscate_decoder_tb;

    localparam int          NO_CUT       = 1024;
    localparam int          PHASE_BEATS  = 300;
    localparam int          SETTLE_GAP   = 8;
    localparam logic [7:0]  SHORTEST_LEN = 8'd5;
    localparam logic [16:0] KELVIN_TENTH = 17'd2732;
    localparam logic [7:0]  OBF_KEY [16] = '{
        8'h19, 8'hF8, 8'h28, 8'h30, 8'h6D, 8'h0C, 8'h94, 8'h54,
        8'h22, 8'hF2, 8'h37, 8'hC9, 8'h66, 8'hA3, 8'h97, 8'h57
    };

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_PAYLOAD,
        FR_CRC_HIGH,
        FR_CRC_LOW
    } frame_phase_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  frame_type;
        logic [31:0] device_id;
        logic [16:0] temperature;
        logic [7:0]  humidity;
        logic [7:0]  battery;
        logic [23:0] power_index;
        logic [15:0] peak_power;
        logic [20:0] timestamp;
    } frame_result_t;

    // DUT ports.
    logic                          clk       = 1'b0;
    logic                          rst_n     = 1'b0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [7:0]                    s_tdata   = 8'h00;  // [7:0] frame_byte
    logic [0:0]                    s_tuser   = 1'b0;   // [0] frame_start
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    // [31:0] device_id, [48:32] temperature_tenths, [56:49] humidity,
    // [64:57] battery_percent, [88:65] power_index, [104:89] peak_power,
    // [125:105] timestamp_seconds
    logic [sfd_pkg::TDATA_W-1:0]   m_tdata;
    // [2:0] status, [10:3] frame_type
    logic [sfd_pkg::TUSER_W-1:0]   m_tuser;
    logic                          cfg_we    = 1'b0;
    logic [7:0]                    cfg_wdata = 8'h00;

    // Flow control and bookkeeping.
    int unsigned   send_idle_pct = 0;
    int unsigned   recv_idle_pct = 0;
    int unsigned   beats_sent    = 0;
    int unsigned   fail_count    = 0;
    frame_result_t expected_frames [$];
    logic [7:0]    frame_plain [256];

    // Decoder state as the testbench sees it.
    logic [7:0]    dec_max_length = 8'd60;
    frame_phase_t  dec_phase      = FR_IDLE;
    logic [7:0]    dec_position   = 8'd0;
    logic [7:0]    dec_length     = 8'd0;
    logic [15:0]   dec_crc16      = 16'hFFFF;
    logic [7:0]    dec_crc8       = 8'd0;
    logic [7:0]    dec_prev_raw   = 8'd0;
    logic [7:0]    dec_crc_high   = 8'd0;
    logic [7:0]    dec_last_byte  = 8'd0;
    logic [7:0]    dec_capture [14];

    sensor_frame_deobfuscate_decoder u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always #2 clk = ~clk;

    // CRC-16, polynomial 0x8005, MSB first.
    function automatic logic [15:0] crc16_step(input logic [15:0] c,
                                               input logic [7:0] b);
        logic [15:0] r;
        r = c ^ {b, 8'h00};
        repeat (8)
        begin
            r = r[15] ? ({r[14:0], 1'b0} ^ 16'h8005) : {r[14:0], 1'b0};
        end
        return r;
    endfunction

    // CRC-8, polynomial 0x07, MSB first.
    function automatic logic [7:0] crc8_step(input logic [7:0] c,
                                             input logic [7:0] b);
        logic [7:0] r;
        r = c ^ b;
        repeat (8)
        begin
            r = r[7] ? ({r[6:0], 1'b0} ^ 8'h07) : {r[6:0], 1'b0};
        end
        return r;
    endfunction

    // Advance the decoder state by one accepted beat and queue the frame
    // result that the beat completes, if any.
    task automatic predict_frame_beat(input logic [7:0] b, input logic st);
        frame_result_t r;
        logic [7:0]    pb;
        logic [7:0]    sub;
        logic [23:0]   stamp;
        int            i;
        r = '0;
        if (st)
        begin
            // A frame start resets the frame state and checks the length at once.
            for (int k = 0; k < 14; k++)
                dec_capture[k] = 8'h00;
            dec_position  = 8'd0;
            dec_length    = b;
            dec_crc16     = crc16_step(16'hFFFF, b);
            dec_crc8      = 8'd0;
            dec_last_byte = 8'd0;
            dec_prev_raw  = b;
            dec_phase     = FR_IDLE;
            if (b > dec_max_length)
            begin
                r.status = sfd_pkg::ST_TOO_LONG;
                expected_frames.push_back(r);
            end
            else if (b < SHORTEST_LEN)
            begin
                r.status = sfd_pkg::ST_TOO_SHORT;
                expected_frames.push_back(r);
            end
            else
            begin
                dec_phase = FR_PAYLOAD;
            end
        end
        else
        begin
            case (dec_phase)
                FR_PAYLOAD:
                begin
                    i  = dec_position;
                    pb = b ^ OBF_KEY[i % 16];
                    if (i > 0)
                        pb = pb ^ dec_prev_raw;
                    dec_crc16 = crc16_step(dec_crc16, b);
                    if (i < 14)
                        dec_capture[i] = pb;
                    // The type byte enters the CRC-8 as the length minus four.
                    if (i == 4)
                    begin
                        sub      = dec_length - 8'd4;
                        dec_crc8 = (dec_length > 8'd5) ? crc8_step(8'h00, sub) : 8'h00;
                        if (i + 1 == dec_length)
                            dec_last_byte = sub;
                    end
                    else if (i > 4)
                    begin
                        if (i + 1 < dec_length)
                            dec_crc8 = crc8_step(dec_crc8, pb);
                        else
                            dec_last_byte = pb;
                    end
                    dec_prev_raw = b;
                    dec_position = 8'(i + 1);
                    if (i + 1 >= dec_length)
                        dec_phase = FR_CRC_HIGH;
                end
                FR_CRC_HIGH:
                begin
                    dec_crc_high = b;
                    dec_phase    = FR_CRC_LOW;
                end
                FR_CRC_LOW:
                begin
                    dec_phase = FR_IDLE;
                    if ({dec_crc_high, b} != dec_crc16)
                    begin
                        r.status = sfd_pkg::ST_CRC16_BAD;
                    end
                    else
                    begin
                        r.status     = sfd_pkg::ST_OK;
                        r.frame_type = dec_capture[4];
                        r.device_id  = {dec_capture[3], dec_capture[2],
                                        dec_capture[1], dec_capture[0]};
                        case (dec_capture[4])
                            sfd_pkg::TYPE_RAW_POWER:
                            begin
                                if (dec_crc8 != dec_last_byte)
                                begin
                                    r.status = sfd_pkg::ST_CRC8_BAD;
                                end
                                else
                                begin
                                    r.power_index = {dec_capture[6], dec_capture[7],
                                                     dec_capture[8]};
                                    stamp = {dec_capture[9], dec_capture[10],
                                             dec_capture[11]};
                                    r.timestamp = stamp[23:3];
                                    r.peak_power = {dec_capture[12], dec_capture[13]};
                                end
                            end
                            sfd_pkg::TYPE_WEATHER:
                            begin
                                r.temperature = {1'b0, dec_capture[6], dec_capture[5]}
                                              - KELVIN_TENTH;
                                r.humidity    = dec_capture[7];
                            end
                            sfd_pkg::TYPE_BATT_LVL:
                                r.battery = dec_capture[5];
                            sfd_pkg::TYPE_BATT_LOW:
                                r.status = sfd_pkg::ST_OK;
                            default:
                                r.status = sfd_pkg::ST_UNKNOWN;
                        endcase
                    end
                    expected_frames.push_back(r);
                end
                default:
                begin
                    // Bytes between frames are ignored.
                end
            endcase
        end
    endtask

    function automatic void check_field(input string name, input logic [31:0] expd,
                                        input logic [31:0] act);
        if (expd !== act)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, expd, act);
            fail_count++;
        end
    endfunction

    // Compare every result beat with the oldest outstanding frame result.
    always @(posedge clk)
    begin : result_check
        frame_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_frames.size() == 0)
            begin
                $error("result beat with no frame outstanding: tuser 0x%0h", m_tuser);
                fail_count++;
            end
            else
            begin
                want = expected_frames.pop_front();
                check_field("status", 32'(want.status), 32'(m_tuser[2:0]));
                check_field("frame_type", 32'(want.frame_type), 32'(m_tuser[10:3]));
                check_field("device_id", want.device_id, m_tdata[31:0]);
                check_field("temperature_tenths", 32'(want.temperature),
                            32'(m_tdata[48:32]));
                check_field("humidity", 32'(want.humidity), 32'(m_tdata[56:49]));
                check_field("battery_percent", 32'(want.battery), 32'(m_tdata[64:57]));
                check_field("power_index", 32'(want.power_index), 32'(m_tdata[88:65]));
                check_field("peak_power", 32'(want.peak_power), 32'(m_tdata[104:89]));
                check_field("timestamp_seconds", 32'(want.timestamp),
                            32'(m_tdata[125:105]));
            end
        end
    end

    // Result-side back-pressure.
    always @(negedge clk)
    begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Send one beat, with random idle cycles ahead of it. Called and returns
    // at a falling edge; valid stays high for a following beat.
    task automatic send_beat(input logic [7:0] b, input logic st);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= st;
        do
            @(posedge clk);
        while (!s_tready);
        predict_frame_beat(b, st);
        beats_sent++;
        @(negedge clk);
    endtask

    // Hold the input until every outstanding frame result has arrived.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_frames.size() != 0)
            @(negedge clk);
        repeat (SETTLE_GAP) @(negedge clk);
    endtask

    task automatic write_max_length(input logic [7:0] value);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we         <= 1'b0;
        dec_max_length  = value;
    endtask

    // Random payload with the given type byte.
    task automatic fill_payload(input logic [7:0] ftype);
        for (int k = 0; k < 256; k++)
            frame_plain[k] = 8'($urandom_range(255));
        frame_plain[4] = ftype;
    endtask

    // Make the last payload byte the CRC-8 that a power frame carries.
    task automatic seal_power_crc(input int len);
        logic [7:0] c;
        if (len > 5)
        begin
            c = crc8_step(8'h00, 8'(len - 4));
            for (int k = 5; k <= len - 2; k++)
                c = crc8_step(c, frame_plain[k]);
            frame_plain[len - 1] = c;
        end
    endtask

    // Obfuscate frame_plain and send the length byte, then at most cut more
    // bytes of data and CRC. A corrupt frame gets a wrong CRC-16 low byte.
    task automatic send_frame(input int len, input int cut, input bit corrupt);
        logic [7:0]  raw;
        logic [7:0]  prev;
        logic [15:0] crc;
        int          n;
        crc  = crc16_step(16'hFFFF, 8'(len));
        prev = 8'h00;
        n    = (cut < len + 2) ? cut : len + 2;
        send_beat(8'(len), 1'b1);
        for (int k = 0; k < n; k++)
        begin
            if (k < len)
            begin
                raw  = frame_plain[k] ^ OBF_KEY[k % 16] ^ ((k > 0) ? prev : 8'h00);
                crc  = crc16_step(crc, raw);
                prev = raw;
                send_beat(raw, 1'b0);
            end
            else if (k == len)
            begin
                send_beat(crc[15:8], 1'b0);
            end
            else
            begin
                send_beat(crc[7:0] ^ (corrupt ? 8'($urandom_range(255, 1)) : 8'h00),
                          1'b0);
            end
        end
    endtask

    // Every frame type, every status and the special cases at the reset limit.
    task automatic test_frame_types();
        send_idle_pct = 23;
        recv_idle_pct = 57;
        // Bytes while idle are ignored.
        send_beat(8'hFF, 1'b0);
        send_beat(8'h00, 1'b0);
        // Weather at the lowest temperature, all-zero device id.
        fill_payload(sfd_pkg::TYPE_WEATHER);
        for (int k = 0; k < 4; k++)
            frame_plain[k] = 8'h00;
        frame_plain[5] = 8'h00;
        frame_plain[6] = 8'h00;
        send_frame(8, NO_CUT, 1'b0);
        // Weather at the highest temperature, all-ones device id.
        fill_payload(sfd_pkg::TYPE_WEATHER);
        for (int k = 0; k < 8; k++)
            frame_plain[k] = (k == 4) ? sfd_pkg::TYPE_WEATHER : 8'hFF;
        send_frame(8, NO_CUT, 1'b0);
        // Short weather frame: humidity lies past the end and reads as zero.
        fill_payload(sfd_pkg::TYPE_WEATHER);
        send_frame(6, NO_CUT, 1'b0);
        // Battery level, and battery low at the shortest length.
        fill_payload(sfd_pkg::TYPE_BATT_LVL);
        frame_plain[5] = 8'hFF;
        send_frame(6, NO_CUT, 1'b0);
        fill_payload(sfd_pkg::TYPE_BATT_LOW);
        send_frame(5, NO_CUT, 1'b0);
        // Raw power with good CRC-8, exactly the capture size and longer.
        fill_payload(sfd_pkg::TYPE_RAW_POWER);
        seal_power_crc(14);
        send_frame(14, NO_CUT, 1'b0);
        fill_payload(sfd_pkg::TYPE_RAW_POWER);
        for (int k = 6; k < 14; k++)
            frame_plain[k] = 8'hFF;
        seal_power_crc(20);
        send_frame(20, NO_CUT, 1'b0);
        // Raw power with bad CRC-8, and at length five where it always fails.
        fill_payload(sfd_pkg::TYPE_RAW_POWER);
        seal_power_crc(12);
        frame_plain[11] = ~frame_plain[11];
        send_frame(12, NO_CUT, 1'b0);
        fill_payload(sfd_pkg::TYPE_RAW_POWER);
        send_frame(5, NO_CUT, 1'b0);
        // Unknown types at both ends of the byte.
        fill_payload(8'h00);
        send_frame(9, NO_CUT, 1'b0);
        fill_payload(8'hFF);
        send_frame(7, NO_CUT, 1'b0);
        // Bad CRC-16.
        fill_payload(sfd_pkg::TYPE_WEATHER);
        send_frame(10, NO_CUT, 1'b1);
        // Too short at zero and four; too long just over the limit and at 255,
        // each followed by bytes that must be ignored.
        send_frame(0, 2, 1'b0);
        send_frame(4, 3, 1'b0);
        send_frame(61, 3, 1'b0);
        send_frame(255, 2, 1'b0);
        // Longest accepted length at reset.
        fill_payload(sfd_pkg::TYPE_BATT_LVL);
        send_frame(60, NO_CUT, 1'b0);
        // A restart in the data and one in the CRC drop those frames silently.
        fill_payload(sfd_pkg::TYPE_WEATHER);
        send_frame(10, 5, 1'b0);
        send_frame(10, 11, 1'b0);
        fill_payload(sfd_pkg::TYPE_BATT_LVL);
        send_frame(7, NO_CUT, 1'b0);
    endtask

    // The length limit at its extremes.
    task automatic test_length_limit();
        write_max_length(8'd255);
        fill_payload(sfd_pkg::TYPE_WEATHER);
        send_frame(255, NO_CUT, 1'b0);
        write_max_length(8'd1);
        send_frame(0, 0, 1'b0);
        send_frame(1, 1, 1'b0);
        send_frame(2, 1, 1'b0);
        send_frame(5, 0, 1'b0);
        write_max_length(8'd5);
        fill_payload(sfd_pkg::TYPE_BATT_LOW);
        send_frame(5, NO_CUT, 1'b0);
        send_frame(6, 2, 1'b0);
        send_frame(4, 0, 1'b0);
    endtask

    // Mostly well-formed frames with random content, plus broken frames,
    // rejected lengths and stray bytes.
    task automatic test_random_traffic(input int unsigned spct, input int unsigned rpct,
                                       input logic [7:0] limit);
        int unsigned stop_at;
        int unsigned pick;
        int          len;
        logic [7:0]  ftype;
        write_max_length(limit);
        send_idle_pct = spct;
        recv_idle_pct = rpct;
        stop_at       = beats_sent + PHASE_BEATS;
        while (beats_sent < stop_at)
        begin
            pick = $urandom_range(99);
            len  = ($urandom_range(9) == 0) ? $urandom_range(int'(limit), 21)
                                            : $urandom_range(20, 5);
            case ($urandom_range(9))
                0, 1, 2: ftype = sfd_pkg::TYPE_RAW_POWER;
                3, 4:    ftype = sfd_pkg::TYPE_WEATHER;
                5, 6:    ftype = sfd_pkg::TYPE_BATT_LVL;
                7:       ftype = sfd_pkg::TYPE_BATT_LOW;
                default: ftype = 8'($urandom_range(255));
            endcase
            fill_payload(ftype);
            if (pick < 70)
            begin
                if ($urandom_range(9) != 0)
                    seal_power_crc(len);
                send_frame(len, NO_CUT, 1'b0);
            end
            else if (pick < 78)
            begin
                send_frame(len, NO_CUT, 1'b1);
            end
            else if (pick < 85)
            begin
                send_frame(len, $urandom_range(len + 1), 1'b0);
            end
            else if (pick < 92)
            begin
                if (limit < 8'd255 && $urandom_range(1) == 0)
                    send_frame($urandom_range(255, int'(limit) + 1), $urandom_range(3),
                               1'b0);
                else
                    send_frame($urandom_range(4), $urandom_range(3), 1'b0);
            end
            else
            begin
                repeat ($urandom_range(4, 1))
                    send_beat(8'($urandom_range(255)), 1'b0);
            end
        end
    endtask

    // Run limit.
    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    initial
    begin
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_frame_types();
        test_length_limit();
        test_random_traffic(23, 57, 8'd255);
        test_random_traffic(57, 23, 8'($urandom_range(254, 21)));
        test_random_traffic(0, 0, 8'd60);

        drain_results();
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/sfd_pkg.sv
rtl/sensor_frame_deobfuscate_decoder.sv
tb/sensor_frame_deobfuscate_decoder_tb.sv
